### sv/dxt_pkg.sv
`default_nettype none
package dxt_pkg;

    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int BLK_W     = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] MAX_DIMENSION = 13'd4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Reciprocals: v*255/31, v*255/63 and x/3, each followed by a right shift
    localparam logic [28:0] EXP5_RECIP = 29'd8625630;  // 255 * 33826, shift 20
    localparam logic [27:0] EXP6_RECIP = 28'd4244475;  // 255 * 16645, shift 20
    localparam logic [19:0] DIV3_RECIP = 20'd683;      // shift 11

    typedef struct packed {
        logic [63:0] color_block;
        logic [63:0] alpha_block;
    } in_t;

    typedef struct packed {
        logic [COORD_W-1:0] texel_x;
        logic [COORD_W-1:0] texel_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic               block_done;
        logic               frame_done;
    } out_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef rgb_t [3:0] pal_t;

endpackage
`default_nettype wire

### sv/dxt_palette.sv
`default_nettype none
module dxt_palette
    import dxt_pkg::*;
(
    input  wire rgb_t ep0,
    input  wire rgb_t ep1,
    input  wire       four_color,
    output pal_t      pal
);

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * DIV3_RECIP;
        return p[18:11];
    endfunction

    // Returns {entry2, entry3} for one channel
    function automatic logic [15:0] mix(input logic [7:0] a, input logic [7:0] b,
                                        input logic fc);
        logic [9:0] s2;
        logic [9:0] s3;
        logic [8:0] sm;
        s2 = {1'b0, a, 1'b0} + 10'(b);
        s3 = 10'(a) + {1'b0, b, 1'b0};
        sm = 9'(a) + 9'(b);
        if (fc)
            return {div3(s2), div3(s3)};
        else
            return {sm[8:1], 8'd0};
    endfunction

    logic [15:0] mr;
    logic [15:0] mg;
    logic [15:0] mb;

    always_comb
    begin
        mr = mix(ep0.r, ep1.r, four_color);
        mg = mix(ep0.g, ep1.g, four_color);
        mb = mix(ep0.b, ep1.b, four_color);
        pal[0] = ep0;
        pal[1] = ep1;
        pal[2] = '{r: mr[15:8], g: mg[15:8], b: mb[15:8]};
        pal[3] = '{r: mr[7:0], g: mg[7:0], b: mb[7:0]};
    end

endmodule
`default_nettype wire

### sv/dxt_block_texel_decoder_core.sv
// A block is registered in a_reg, moves with its palette into b_reg once b_reg is free,
// and each texel is registered in the output register. One texel per cycle while out_ready
// holds; a block yields its texels inside the image (16 for an interior block), the next
// block is taken in while the current one drains; one wholly outside the image is dropped.
// Reset (rst_n low, asynchronous): pipeline empties, block position goes to column 0,
// row 0, and configuration returns to DXT1 with a 4x4 image.
`default_nettype none
module dxt_block_texel_decoder_core
    import dxt_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire in_t            in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output out_t                out_data,
    input  wire                 cfg_we,
    input  wire [CFG_IDX_W-1:0] cfg_index,
    input  wire [DIM_W-1:0]     cfg_data
);

    typedef struct packed {
        rgb_t               ep0;
        rgb_t               ep1;
        logic               four_color;
        logic [31:0]        idx;
        logic [63:0]        alpha;
        logic               mode;
        logic [BLK_W-1:0]   bx;
        logic [BLK_W-1:0]   by;
        logic [1:0]         ncm1;
        logic [1:0]         nrm1;
        logic               last;
    } a_blk_t;

    typedef struct packed {
        pal_t               pal;
        logic [31:0]        idx;
        logic [63:0]        alpha;
        logic               mode;
        logic [BLK_W-1:0]   bx;
        logic [BLK_W-1:0]   by;
        logic [1:0]         ncm1;
        logic [1:0]         nrm1;
        logic               last;
    } b_blk_t;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [28:0] p;
        p = 29'(v) * EXP5_RECIP;
        return p[27:20];
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [27:0] p;
        p = 28'(v) * EXP6_RECIP;
        return p[27:20];
    endfunction

    function automatic rgb_t expand(input logic [15:0] c);
        rgb_t e;
        e.r = expand5(c[15:11]);
        e.g = expand6(c[10:5]);
        e.b = expand5(c[4:0]);
        return e;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        else if (v > MAX_DIMENSION)
            return MAX_DIMENSION;
        else
            return v;
    endfunction

    logic               mode_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [BLK_W-1:0]   col_reg;
    logic [BLK_W-1:0]   col_next;
    logic [BLK_W-1:0]   row_reg;
    logic [BLK_W-1:0]   row_next;

    logic               a_vld_reg;
    a_blk_t             a_reg;
    a_blk_t             a_next;
    logic               b_vld_reg;
    b_blk_t             b_reg;
    logic [1:0]         cx_reg;
    logic [1:0]         cy_reg;
    logic               o_vld_reg;
    out_t               o_reg;
    out_t               o_next;

    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [BLK_W:0]     bw4;
    logic [BLK_W:0]     bh4;
    logic               col_last;
    logic               row_last;
    logic [DIM_W-1:0]   x0;
    logic [DIM_W-1:0]   y0;
    logic [DIM_W-1:0]   cols_left;
    logic [DIM_W-1:0]   rows_left;
    logic               empty;

    logic               in_fire;
    logic               out_free;
    logic               b_emit;
    logic               b_last;
    logic               b_free;
    logic               a_move;
    pal_t               pal;
    logic [3:0]         t;
    logic [1:0]         sel;
    logic [3:0]         nib;

    assign out_free = !o_vld_reg || out_ready;
    assign b_last   = (cx_reg == b_reg.ncm1) && (cy_reg == b_reg.nrm1);
    assign b_emit   = b_vld_reg && out_free;
    assign b_free   = !b_vld_reg || (b_emit && b_last);
    assign a_move   = a_vld_reg && b_free;
    assign in_ready = !a_vld_reg || a_move;
    assign in_fire  = in_valid && in_ready;

    // Block position and the visible part of the block
    always_comb
    begin
        w         = clamp_dim(width_reg);
        h         = clamp_dim(height_reg);
        bw4       = (BLK_W+1)'((14'(w) + 14'd3) >> 2);
        bh4       = (BLK_W+1)'((14'(h) + 14'd3) >> 2);
        col_last  = ((BLK_W+1)'(col_reg) + (BLK_W+1)'(1)) >= bw4;
        row_last  = ((BLK_W+1)'(row_reg) + (BLK_W+1)'(1)) >= bh4;
        x0        = {1'b0, col_reg, 2'b00};
        y0        = {1'b0, row_reg, 2'b00};
        cols_left = w - x0;
        rows_left = h - y0;
        empty     = (x0 >= w) || (y0 >= h);

        col_next = col_reg;
        row_next = row_reg;
        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_reg + BLK_W'(1);
        end
        else
        begin
            col_next = col_reg + BLK_W'(1);
        end

        a_next.ep0        = expand(in_data.color_block[15:0]);
        a_next.ep1        = expand(in_data.color_block[31:16]);
        a_next.four_color = mode_reg
                            || (in_data.color_block[15:0] > in_data.color_block[31:16]);
        a_next.idx        = in_data.color_block[63:32];
        a_next.alpha      = in_data.alpha_block;
        a_next.mode       = mode_reg;
        a_next.bx         = col_reg;
        a_next.by         = row_reg;
        a_next.ncm1       = (cols_left > DIM_W'(3)) ? 2'd3 : 2'(cols_left - DIM_W'(1));
        a_next.nrm1       = (rows_left > DIM_W'(3)) ? 2'd3 : 2'(rows_left - DIM_W'(1));
        a_next.last       = col_last && row_last;
    end

    dxt_palette u_palette (
        .ep0        (a_reg.ep0),
        .ep1        (a_reg.ep1),
        .four_color (a_reg.four_color),
        .pal        (pal)
    );

    // Texel select from the emitting block
    always_comb
    begin
        t   = {cy_reg, cx_reg};
        sel = b_reg.idx[{t, 1'b0} +: 2];
        nib = b_reg.alpha[{t, 2'b00} +: 4];
        o_next.texel_x    = {b_reg.bx, cx_reg};
        o_next.texel_y    = {b_reg.by, cy_reg};
        o_next.red        = b_reg.pal[sel].r;
        o_next.green      = b_reg.pal[sel].g;
        o_next.blue       = b_reg.pal[sel].b;
        o_next.alpha      = b_reg.mode ? {nib, nib} : 8'hFF;
        o_next.block_done = b_last;
        o_next.frame_done = b_last && b_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            width_reg  <= DIM_W'(4);
            height_reg <= DIM_W'(4);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                // drop a block that lies wholly outside the image
                a_vld_reg <= !empty;
            end
            else if (a_move)
            begin
                a_vld_reg <= 1'b0;
            end

            if (a_move)
            begin
                b_vld_reg <= 1'b1;
                cx_reg    <= '0;
                cy_reg    <= '0;
            end
            else if (b_emit)
            begin
                if (b_last)
                    b_vld_reg <= 1'b0;
                if (cx_reg == b_reg.ncm1)
                begin
                    cx_reg <= '0;
                    cy_reg <= cy_reg + 2'd1;
                end
                else
                begin
                    cx_reg <= cx_reg + 2'd1;
                end
            end

            if (b_emit)
                o_vld_reg <= 1'b1;
            else if (out_ready)
                o_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            a_reg <= a_next;
        if (a_move)
        begin
            b_reg.pal   <= pal;
            b_reg.idx   <= a_reg.idx;
            b_reg.alpha <= a_reg.alpha;
            b_reg.mode  <= a_reg.mode;
            b_reg.bx    <= a_reg.bx;
            b_reg.by    <= a_reg.by;
            b_reg.ncm1  <= a_reg.ncm1;
            b_reg.nrm1  <= a_reg.nrm1;
            b_reg.last  <= a_reg.last;
        end
        if (b_emit)
            o_reg <= o_next;
    end

    assign out_valid = o_vld_reg;
    assign out_data  = o_reg;

endmodule
`default_nettype wire

### sv/dxt_checker.sv
`default_nettype none
module dxt_checker
    import dxt_pkg::*;
(
    input wire       clk,
    input wire       rst_n,
    input wire       out_valid,
    input wire       out_ready,
    input wire out_t out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_frame_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.frame_done || out_data.block_done))
        else $error("frame_done without block_done");

    // A texel that is not the last of its block is followed by one of the same block
    a_same_block: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.block_done) ##1 out_valid |->
            (out_data.texel_x[COORD_W-1:2] == $past(out_data.texel_x[COORD_W-1:2]))
            && (out_data.texel_y[COORD_W-1:2] == $past(out_data.texel_y[COORD_W-1:2])))
        else $error("block changed before block_done");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind dxt_block_texel_decoder_core dxt_checker u_dxt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

### tb/dxt_block_texel_decoder_core_tb.sv
`default_nettype none
module dxt_block_texel_decoder_core_tb;
    import dxt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_AT = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int DIR_ROWS = 25;
    localparam int PHASES = 8;

    typedef struct packed {
        logic               mode;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [63:0]        color;
        logic [63:0]        alpha;
        logic               typed;
        logic [31:0]        rgba;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_t                  in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_t                 out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    // Shadow of the block's registers and block position
    logic                 cur_mode;
    logic [DIM_W-1:0]     cur_width;
    logic [DIM_W-1:0]     cur_height;
    int unsigned          blk_col;
    int unsigned          blk_row;

    out_t                 pending_texels[$];
    dir_row_t             dir_tab[DIR_ROWS];

    int                   errors;
    int                   blocks_sent;
    int                   blocks_dropped;
    int                   texels_checked;
    int                   frames_seen;
    int                   settings_used;
    int                   burst_left;
    bit                   gappy;
    int unsigned          cycle;
    int                   hold_left;
    bit                   hold_done;

    dxt_block_texel_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d texels still expected", cycle,
                     pending_texels.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Expand the endpoints, build the palette and list the texels inside the image
    function automatic void decode_block(in_t blk, bit typed, logic [31:0] rgba);
        int unsigned w;
        int unsigned h;
        int unsigned cols;
        int unsigned rows;
        int unsigned c0;
        int unsigned c1;
        int unsigned x;
        int unsigned y;
        int unsigned sel;
        int unsigned ep[2][3];
        int unsigned pal[4][3];
        bit          last_blk;
        out_t        tx;
        out_t        found[$];

        w = (cur_width == 0) ? 1 : (cur_width > MAX_DIMENSION) ? MAX_DIMENSION : cur_width;
        h = (cur_height == 0) ? 1 : (cur_height > MAX_DIMENSION) ? MAX_DIMENSION : cur_height;
        cols = (w + 3) / 4;
        rows = (h + 3) / 4;
        c0 = blk.color_block[15:0];
        c1 = blk.color_block[31:16];
        last_blk = (blk_col + 1 >= cols) && (blk_row + 1 >= rows);

        ep[0][0] = ((c0 >> 11) & 31) * 255 / 31;
        ep[0][1] = ((c0 >> 5) & 63) * 255 / 63;
        ep[0][2] = (c0 & 31) * 255 / 31;
        ep[1][0] = ((c1 >> 11) & 31) * 255 / 31;
        ep[1][1] = ((c1 >> 5) & 63) * 255 / 63;
        ep[1][2] = (c1 & 31) * 255 / 31;
        for (int k = 0; k < 3; k++)
        begin
            pal[0][k] = ep[0][k];
            pal[1][k] = ep[1][k];
            if (cur_mode || c0 > c1)
            begin
                pal[2][k] = (2 * ep[0][k] + ep[1][k]) / 3;
                pal[3][k] = (ep[0][k] + 2 * ep[1][k]) / 3;
            end
            else
            begin
                pal[2][k] = (ep[0][k] + ep[1][k]) / 2;
                pal[3][k] = 0;
            end
        end

        for (int t = 0; t < 16; t++)
        begin
            x = blk_col * 4 + (t & 3);
            y = blk_row * 4 + (t >> 2);
            if (x >= w || y >= h)
                continue;
            sel = blk.color_block[32 + 2 * t +: 2];
            tx = '0;
            tx.texel_x = x[COORD_W-1:0];
            tx.texel_y = y[COORD_W-1:0];
            tx.red = pal[sel][0][7:0];
            tx.green = pal[sel][1][7:0];
            tx.blue = pal[sel][2][7:0];
            tx.alpha = cur_mode ? 8'(blk.alpha_block[4 * t +: 4] * 17) : 8'd255;
            if (typed)
            begin
                tx.red = rgba[31:24];
                tx.green = rgba[23:16];
                tx.blue = rgba[15:8];
                tx.alpha = rgba[7:0];
            end
            found = {found, tx};
        end

        if (found.size() > 0)
        begin
            found[found.size() - 1].block_done = 1'b1;
            found[found.size() - 1].frame_done = last_blk;
            pending_texels = {pending_texels, found};
        end
        else
        begin
            blocks_dropped++;
        end

        if (blk_col + 1 >= cols)
        begin
            blk_col = 0;
            blk_row = (blk_row + 1 >= rows) ? 0 : ((blk_row + 1) & 10'h3FF);
        end
        else
        begin
            blk_col = (blk_col + 1) & 10'h3FF;
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic in_t random_block();
        in_t blk;

        blk.color_block = {$urandom, $urandom};
        blk.alpha_block = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: blk.color_block[31:16] = blk.color_block[15:0];
            1: blk.alpha_block = $urandom_range(0, 1) ? '1 : '0;
            2: blk.color_block[63:32] = {16{2'($urandom_range(0, 3))}};
            default: ;
        endcase
        return blk;
    endfunction

    // Offer one block in bursts with random gaps; predict on transfer
    task automatic offer_block(in_t blk, bit typed, logic [31:0] rgba);
        int gap;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (!gappy || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= blk;
        do
            @(posedge clk);
        while (!in_ready);
        blocks_sent++;
        decode_block(blk, typed, rgba);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_texels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic mode, logic [DIM_W-1:0] width, logic [DIM_W-1:0] height);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data <= {{(DIM_W-1){1'b0}}, mode};
        @(posedge clk);
        cfg_index <= CFG_WIDTH;
        cfg_data <= width;
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data <= height;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_mode = mode;
        cur_width = width;
        cur_height = height;
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && blocks_sent >= HOLD_AT)
            begin
                // Hold off long enough for the block to back up into its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                case (cycle[8:7])
                    2'd0: out_ready <= 1'b1;
                    2'd1: out_ready <= ($urandom_range(0, 3) != 0);
                    2'd2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= cycle[1];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        out_t want;

        if (rst_n && out_valid && out_ready)
        begin
            texels_checked++;
            if (out_data.frame_done)
                frames_seen++;
            if (pending_texels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected texel: expected none, got %h", $time, out_data);
            end
            else
            begin
                want = pending_texels.pop_front();
                check_field("texel_x", want.texel_x, out_data.texel_x);
                check_field("texel_y", want.texel_y, out_data.texel_y);
                check_field("red", want.red, out_data.red);
                check_field("green", want.green, out_data.green);
                check_field("blue", want.blue, out_data.blue);
                check_field("alpha", want.alpha, out_data.alpha);
                check_field("block_done", want.block_done, out_data.block_done);
                check_field("frame_done", want.frame_done, out_data.frame_done);
            end
        end
    end

    initial
    begin
        int          ph_mode[PHASES];
        int          ph_width[PHASES];
        int          ph_height[PHASES];
        int          ph_count[PHASES];
        dir_row_t    row;
        in_t         blk;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        cycle = 0;
        errors = 0;
        blocks_sent = 0;
        blocks_dropped = 0;
        texels_checked = 0;
        frames_seen = 0;
        settings_used = 1;
        burst_left = 0;
        gappy = 1'b1;
        hold_left = 0;
        hold_done = 1'b0;
        cur_mode = 1'b0;
        cur_width = 13'd4;
        cur_height = 13'd4;
        blk_col = 0;
        blk_row = 0;

        // mode, width, height, color, alpha, typed, rgba of every texel when typed
        dir_tab = '{
            '{1'b0, 13'd4, 13'd4, 64'h0000_0000_0000_0000, 64'h0, 1'b1, 32'h0000_00FF},
            '{1'b0, 13'd4, 13'd4, 64'h0000_0000_FFFF_FFFF, 64'h0, 1'b1, 32'hFFFF_FFFF},
            '{1'b0, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_0000, 64'h0, 1'b1, 32'h0000_00FF},
            '{1'b0, 13'd4, 13'd4, 64'hAAAA_AAAA_FFFF_0000, 64'h0, 1'b1, 32'h7F7F_7FFF},
            '{1'b0, 13'd4, 13'd4, 64'hAAAA_AAAA_0000_FFFF, 64'h0, 1'b1, 32'hAAAA_AAFF},
            '{1'b0, 13'd4, 13'd4, 64'hFFFF_FFFF_0000_FFFF, 64'h0, 1'b1, 32'h5555_55FF},
            '{1'b0, 13'd4, 13'd4, 64'h5555_5555_001F_F800, 64'h0, 1'b1, 32'h0000_FFFF},
            '{1'b0, 13'd4, 13'd4, 64'h1B1B_1B1B_07E0_F81F, 64'h0, 1'b0, 32'h0},
            '{1'b0, 13'd4, 13'd4, 64'hE4E4_E4E4_1234_1234, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
            '{1'b1, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              32'hAAAA_AAFF},
            '{1'b1, 13'd4, 13'd4, 64'h0000_0000_0000_0000, 64'h0, 1'b1, 32'h0000_0000},
            '{1'b1, 13'd4, 13'd4, 64'h1B1B_E4E4_7BEF_8410, 64'hFEDC_BA98_7654_3210, 1'b0, 32'h0},
            '{1'b0, 13'd1, 13'd1, 64'h0000_0000_FFFF_FFFF, 64'h0, 1'b1, 32'hFFFF_FFFF},
            '{1'b0, 13'd0, 13'd0, 64'h0000_0000_FFFF_FFFF, 64'h0, 1'b1, 32'hFFFF_FFFF},
            '{1'b0, 13'd5, 13'd6, 64'h27D8_9C63_F81F_07E0, 64'h0, 1'b0, 32'h0},
            '{1'b0, 13'd5, 13'd6, 64'h3210_FEDC_001F_FFE0, 64'h0, 1'b0, 32'h0},
            '{1'b0, 13'd5, 13'd6, 64'hFFFF_0000_8000_7FFF, 64'h0, 1'b0, 32'h0},
            '{1'b0, 13'd5, 13'd6, 64'h0123_4567_89AB_CDEF, 64'h0, 1'b0, 32'h0},
            '{1'b0, 13'd8191, 13'd1, 64'h5A5A_A5A5_4321_8765, 64'h0, 1'b0, 32'h0},
            '{1'b0, 13'd4097, 13'd4, 64'h9696_6969_FFDF_0020, 64'h0, 1'b0, 32'h0},
            '{1'b1, 13'd4, 13'd8, 64'h1234_5678_ABCD_EF01, 64'h0F1E_2D3C_4B5A_6978, 1'b0, 32'h0},
            '{1'b1, 13'd4, 13'd8, 64'hD2B4_8E71_6B5A_39CE, 64'h8899_AABB_CCDD_EEFF, 1'b0, 32'h0},
            '{1'b0, 13'd4096, 13'd4096, 64'h7777_8888_1111_EEEE, 64'h0, 1'b0, 32'h0},
            '{1'b0, 13'd3, 13'd3, 64'h3C3C_C3C3_5AA5_A55A, 64'h0, 1'b0, 32'h0},
            '{1'b0, 13'd3, 13'd3, 64'hB1B1_4E4E_F00F_0FF0, 64'h0, 1'b0, 32'h0}
        };

        ph_mode = '{0, 1, 0, 1, 1, 0, 0, 1};
        ph_width = '{13, 7, 4096, 1, 16, 3, 5000, 2};
        ph_height = '{9, 6, 2, 4096, 16, 5, 3, 2};
        ph_count = '{60, 60, 40, 40, 60, 50, 30, 50};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_tab[i];
            if (row.mode != cur_mode || row.width != cur_width || row.height != cur_height)
            begin
                drain();
                configure(row.mode, row.width, row.height);
            end
            blk.color_block = row.color;
            blk.alpha_block = row.alpha;
            offer_block(blk, row.typed, row.rgba);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            configure(ph_mode[p][0], ph_width[p][DIM_W-1:0], ph_height[p][DIM_W-1:0]);
            // first phase runs back to back
            gappy = (p != 0);
            burst_left = 0;
            for (int n = 0; n < ph_count[p]; n++)
                offer_block(random_block(), 1'b0, 32'h0);
        end

        drain();
        $display("Run covered %0d blocks over %0d register settings in DXT1 and DXT3,",
                 blocks_sent, settings_used);
        $display("%0d texels checked, %0d frame ends, %0d blocks outside the image",
                 texels_checked, frames_seen, blocks_dropped);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
